// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the following cycle, outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Types, character constants and classification helpers for the sentence
// boundary splitter.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // One queued job: bytes to judge (oldest in entry 0), how many of them
    // are judged, and whether the job closes a paragraph.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      nj;
        logic            is_end;
    } sbs_job_t;

    typedef enum logic [2:0] {
        PH_JUDGE = 3'b001,
        PH_NL    = 3'b010,
        PH_END   = 3'b100
    } sbs_phase_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_mark(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUERY);
    endfunction

endpackage

// ===== hw/rtl/sentence_boundary_splitter.sv =====
// A byte that completes a job goes into the queue, then into the job register of an
// idle back end, and its first result shows from the output register.
// Throughput: one input byte per cycle while the job queue has room; the back end gives
// one result per cycle unless out_ready holds it; each judged byte, break and closing
// newline takes a step, and a paragraph end judges up to four bytes.
// Reset: rst_n empties the window and the queue, clears the sentence state and out_valid.
// ----------------------------------------------------------------------------
// sentence_boundary_splitter
// Re-emits paragraph text with a newline after each sentence end and each paragraph end.
// ----------------------------------------------------------------------------
module sentence_boundary_splitter
    import sbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       para_end,
    input  logic       empty_para,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    logic     q_full;
    logic     push;
    sbs_job_t push_job;
    logic     pop;
    logic     q_valid;
    sbs_job_t head;

    sbs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .para_end   (para_end),
        .empty_para (empty_para),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    sbs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    sbs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

// ===== hw/rtl/sbs_front.sv =====
// ----------------------------------------------------------------------------
// sbs_front
// Accepts text bytes, keeps the three-byte lookahead window and turns each
// byte that needs an answer into a job for the back end.
// ----------------------------------------------------------------------------
module sbs_front
    import sbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       para_end,
    input  logic       empty_para,
    input  logic       q_full,
    output logic       push,
    output sbs_job_t   push_job
);

    logic [7:0] win_reg  [3];
    logic [7:0] win_next [3];
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       accept;
    logic       mid;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign mid      = !empty_para && !para_end;

    always_comb
    begin
        win_next  = win_reg;
        fill_next = fill_reg;
        push      = 1'b0;
        push_job  = '0;
        if (accept)
        begin
            if (mid)
            begin
                if (fill_reg != 2'd3)
                begin
                    win_next[fill_reg] = ch;
                    fill_next          = fill_reg + 2'd1;
                end
                else
                begin
                    // Full window: the oldest byte is judged with three bytes ahead.
                    push             = 1'b1;
                    push_job.data[0] = win_reg[0];
                    push_job.data[1] = win_reg[1];
                    push_job.data[2] = win_reg[2];
                    push_job.data[3] = ch;
                    push_job.nj      = 3'd1;
                    push_job.is_end  = 1'b0;
                    win_next[0]      = win_reg[1];
                    win_next[1]      = win_reg[2];
                    win_next[2]      = ch;
                end
            end
            else
            begin
                push = 1'b1;
                for (int j = 0; j < 3; j++)
                begin
                    push_job.data[j] = (3'(j) < {1'b0, fill_reg}) ? win_reg[j] : ch;
                end
                push_job.data[3] = ch;
                push_job.nj      = {1'b0, fill_reg} + {2'b00, !empty_para};
                push_job.is_end  = 1'b1;
                fill_next        = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// ===== hw/rtl/sbs_fifo.sv =====
// ----------------------------------------------------------------------------
// sbs_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module sbs_fifo
    import sbs_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sbs_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     q_valid,
    output sbs_job_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sbs_job_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/sbs_back.sv =====
// ----------------------------------------------------------------------------
// sbs_back
// Takes jobs from the queue, judges one byte per step against the sentence
// rules and drives the registered output channel, one result per cycle unless out_ready holds it.
// ----------------------------------------------------------------------------
module sbs_back
    import sbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  sbs_job_t   head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    sbs_job_t   job_reg, job_next;
    logic       job_valid_reg, job_valid_next;
    logic [2:0] rem_reg, rem_next;
    sbs_phase_t phase_reg, phase_next;
    logic [7:0] prev_reg, prev_next;
    logic [7:0] prev2_reg, prev2_next;
    logic       nan_reg, nan_next;
    logic       wfl_reg, wfl_next;
    logic       ocs_reg, ocs_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       last_reg, last_next;

    logic [7:0] c, p, n1, la1, la2;
    logic [1:0] k;
    logic       advance;
    logic       skip, brk, set_nan;
    logic       wfl_t, ocs_t;
    logic       j_emit_char, j_emit_nl, j_nan, j_wfl;
    logic       emit;
    logic [7:0] emit_char;
    logic       emit_last;
    logic       byte_done, job_done;

    assign c   = job_reg.data[0];
    assign la1 = job_reg.data[2];
    assign la2 = job_reg.data[3];
    assign p   = prev_reg;
    // Bytes ahead run out towards the paragraph end.
    assign k   = job_reg.is_end ? 2'(rem_reg - 3'd1) : 2'd3;
    assign n1  = (k != 2'd0) ? job_reg.data[1] : 8'd0;

    assign advance = job_valid_reg && (!out_valid_reg || out_ready);

    // Rule evaluation for the byte at the head of the current job.
    always_comb
    begin
        skip  = 1'b0;
        wfl_t = wfl_reg;
        ocs_t = ocs_reg;
        if (wfl_reg)
        begin
            if (is_letter(c))
            begin
                wfl_t = 1'b0;
                ocs_t = 1'b0;
            end
            else if ((c == CH_LPAREN) && !ocs_reg)
            begin
                wfl_t = 1'b0;
            end
            else
            begin
                if (c != CH_SPACE)
                begin
                    ocs_t = 1'b1;
                end
                skip = 1'b1;
            end
        end

        brk     = 1'b0;
        set_nan = 1'b0;
        if (is_mark(c))
        begin
            priority if (is_letter(p) && (k != 2'd0) && (n1 == CH_SPACE)
                         && (prev2_reg != CH_DOT))
            begin
                brk = 1'b1;
            end
            else if (p == CH_RPAREN)
            begin
                brk = 1'b1;
            end
            else if ((k != 2'd0) && (n1 == CH_RPAREN))
            begin
                // The break moves behind the closing bracket.
                if (k == 2'd1)
                begin
                    set_nan = 1'b1;
                end
                else if ((la1 == CH_SPACE) && ((k == 2'd2) || is_upper(la2)))
                begin
                    set_nan = 1'b1;
                end
            end
            else if (k == 2'd0)
            begin
                brk = 1'b1;
            end
            else if ((p == CH_SPACE) && (n1 == CH_SPACE))
            begin
                brk = (k >= 2'd2) && is_upper(la1);
            end
            else if ((p == CH_DOT) && (n1 == CH_SPACE))
            begin
                brk = 1'b1;
            end
        end
        else
        begin
            brk = (k == 2'd0);
        end

        if (nan_reg)
        begin
            j_emit_char = 1'b1;
            j_emit_nl   = 1'b1;
            j_nan       = 1'b0;
            j_wfl       = 1'b1;
        end
        else
        begin
            j_emit_char = !skip;
            j_emit_nl   = !skip && brk;
            j_nan       = !skip && set_nan;
            j_wfl       = (!skip && brk) ? 1'b1 : wfl_t;
        end
    end

    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        rem_next       = rem_reg;
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        prev2_next     = prev2_reg;
        nan_next       = nan_reg;
        wfl_next       = wfl_reg;
        ocs_next       = ocs_reg;
        emit           = 1'b0;
        emit_char      = c;
        emit_last      = 1'b0;
        byte_done      = 1'b0;
        job_done       = 1'b0;

        if (advance)
        begin
            unique case (phase_reg)
                PH_JUDGE:
                begin
                    nan_next   = j_nan;
                    wfl_next   = j_wfl;
                    ocs_next   = nan_reg ? ocs_reg : ocs_t;
                    prev2_next = prev_reg;
                    prev_next  = c;
                    emit       = j_emit_char;
                    emit_char  = c;
                    emit_last  = !job_reg.is_end && !j_emit_nl;
                    if (j_emit_nl)
                    begin
                        phase_next = PH_NL;
                    end
                    else
                    begin
                        byte_done = 1'b1;
                    end
                end
                PH_NL:
                begin
                    emit      = 1'b1;
                    emit_char = CH_NL;
                    emit_last = !job_reg.is_end;
                    byte_done = 1'b1;
                end
                PH_END:
                begin
                    emit       = 1'b1;
                    emit_char  = CH_NL;
                    emit_last  = 1'b1;
                    job_done   = 1'b1;
                    prev_next  = 8'd0;
                    prev2_next = 8'd0;
                    nan_next   = 1'b0;
                    wfl_next   = 1'b0;
                    ocs_next   = 1'b0;
                end
                default:
                begin
                    phase_next = PH_JUDGE;
                end
            endcase
        end

        if (byte_done)
        begin
            job_next.data = {8'd0, job_reg.data[3:1]};
            rem_next      = rem_reg - 3'd1;
            if (rem_reg == 3'd1)
            begin
                if (job_reg.is_end)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    job_done = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_JUDGE;
            end
        end

        pop = q_valid && (!job_valid_reg || job_done);
        if (pop)
        begin
            job_next       = head;
            job_valid_next = 1'b1;
            rem_next       = head.nj;
            phase_next     = (head.is_end && (head.nj == 3'd0)) ? PH_END : PH_JUDGE;
        end
        else if (job_done)
        begin
            job_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            last_next      = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_reg       <= 3'd0;
            phase_reg     <= PH_JUDGE;
            prev_reg      <= 8'd0;
            prev2_reg     <= 8'd0;
            nan_reg       <= 1'b0;
            wfl_reg       <= 1'b0;
            ocs_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            rem_reg       <= rem_next;
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            prev2_reg     <= prev2_next;
            nan_reg       <= nan_next;
            wfl_reg       <= wfl_next;
            ocs_reg       <= ocs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

endmodule

// ===== hw/rtl/sbs_checker.sv =====
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks on the sentence boundary splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] ch,
    input logic       para_end,
    input logic       empty_para,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_of_run
);

    logic seen_input_reg;

    // Set once any input transfer has taken place since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_input_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_input_reg <= 1'b1;
        end
    end

    `ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "out_valid dropped before transfer")
    `ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(out_char) && $stable(last_of_run), "output payload changed while stalled")
    `ASSERT_CLK(a_no_invented_output, !out_valid || seen_input_reg, "result offered before any input transfer")

endmodule

bind sentence_boundary_splitter sbs_checker u_sbs_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sentence boundary splitter testbench
// Streams directed and randomly built paragraphs through the splitter with
// random gaps on both sides and a long output stall, predicts every output
// byte in a behavioural model of the splitting rules, and compares each
// output transfer in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    import sbs_pkg::*;

    localparam int ITEM_TARGET  = 260;
    localparam int IDLE_PERCENT = 19;
    localparam int HOLD_CYCLES  = 160;
    localparam int HOLD_AFTER   = 40;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       para_end;
        logic       empty_para;
    } text_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_flag;
    } out_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       para_end = 1'b0;
    logic       empty_para = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;

    text_item_t pending_q[$];
    out_byte_t  expected_q[$];
    out_byte_t  run_q[$];
    logic [7:0] para_q[$];

    // Splitter state as predicted.
    logic [7:0] win [3];
    int         win_fill;
    logic [7:0] prev_c;
    logic [7:0] prev2_c;
    bit         nl_pending;
    bit         want_letter;
    bit         junk_seen;

    int sent_count = 0;
    int recv_count = 0;
    int error_count = 0;
    int para_count = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    // Both sides stop idling for a stretch in the middle of the run.
    wire calm = (sent_count >= 150) && (sent_count < 210);

    sentence_boundary_splitter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .para_end   (para_end),
        .empty_para (empty_para),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    function automatic bit capital(input logic [7:0] c);
        return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
    endfunction

    function automatic bit alpha(input logic [7:0] c);
        return capital(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic bit stop_mark(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_BANG) || (c == CH_QUERY);
    endfunction

    task automatic emit(input logic [7:0] v);
        run_q.push_back('{out_char: v, last_flag: 1'b0});
    endtask

    task automatic clear_para();
        win[0] = 8'h00;
        win[1] = 8'h00;
        win[2] = 8'h00;
        win_fill = 0;
        prev_c = 8'h00;
        prev2_c = 8'h00;
        nl_pending = 1'b0;
        want_letter = 1'b0;
        junk_seen = 1'b0;
    endtask

    // Decides the output for byte c, given k following bytes (3 means three or more).
    task automatic judge_byte(input logic [7:0] c, input logic [7:0] f1, input logic [7:0] f2,
                              input logic [7:0] f3, input int k);
        logic [7:0] p;
        logic [7:0] n1;
        bit         skip;
        bit         brk;
        p = prev_c;
        skip = 1'b0;
        brk = 1'b0;
        if (nl_pending) begin
            emit(c);
            emit(CH_NL);
            nl_pending = 1'b0;
            want_letter = 1'b1;
        end
        else begin
            if (want_letter) begin
                if (alpha(c)) begin
                    want_letter = 1'b0;
                    junk_seen = 1'b0;
                end
                else if (c == CH_LPAREN && !junk_seen) begin
                    want_letter = 1'b0;
                end
                else begin
                    if (c != CH_SPACE)
                        junk_seen = 1'b1;
                    skip = 1'b1;
                end
            end
            if (!skip) begin
                n1 = (k >= 1) ? f1 : 8'h00;
                if (stop_mark(c)) begin
                    if (alpha(p) && k >= 1 && n1 == CH_SPACE && prev2_c != CH_DOT)
                        brk = 1'b1;
                    else if (p == CH_RPAREN)
                        brk = 1'b1;
                    else if (k >= 1 && n1 == CH_RPAREN) begin
                        // The break moves to just after the closing bracket.
                        if (k < 2)
                            nl_pending = 1'b1;
                        else if (f2 == CH_SPACE && (k < 3 || capital(f3)))
                            nl_pending = 1'b1;
                    end
                    else if (k == 0)
                        brk = 1'b1;
                    else if (p == CH_SPACE && n1 == CH_SPACE)
                        brk = (k >= 2) && capital(f2);
                    else if (p == CH_DOT && n1 == CH_SPACE)
                        brk = 1'b1;
                end
                else begin
                    brk = (k == 0);
                end
                emit(c);
                if (brk) begin
                    emit(CH_NL);
                    want_letter = 1'b1;
                end
            end
        end
        prev2_c = prev_c;
        prev_c = c;
    endtask

    task automatic predict_split(input logic [7:0] c, input logic pe, input logic ep);
        logic [7:0] held [7];
        int         len;
        int         k;
        int         i;
        run_q.delete();
        if (!ep && !pe) begin
            if (win_fill < 3) begin
                win[win_fill] = c;
                win_fill++;
            end
            else begin
                judge_byte(win[0], win[1], win[2], c, 3);
                win[0] = win[1];
                win[1] = win[2];
                win[2] = c;
            end
        end
        else begin
            for (i = 0; i < 7; i++)
                held[i] = 8'h00;
            for (i = 0; i < win_fill; i++)
                held[i] = win[i];
            len = win_fill;
            if (!ep) begin
                held[len] = c;
                len++;
            end
            for (i = 0; i < len; i++) begin
                k = len - 1 - i;
                if (k > 3)
                    k = 3;
                judge_byte(held[i], held[i + 1], held[i + 2], held[i + 3], k);
            end
            emit(CH_NL);
            clear_para();
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last_flag = 1'b1;
        foreach (run_q[j])
            expected_q.push_back(run_q[j]);
    endtask

    task automatic add_item(input logic [7:0] c, input logic pe, input logic ep);
        pending_q.push_back('{ch: c, para_end: pe, empty_para: ep});
    endtask

    task automatic add_text(input string s, input bit close);
        int i;
        for (i = 0; i < s.len(); i++)
            add_item(s[i], close && (i == s.len() - 1), 1'b0);
    endtask

    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            para_q.push_back(s[i]);
    endtask

    // Builds one paragraph of word-like text with sentence punctuation.
    task automatic build_paragraph();
        int tokens;
        int t;
        int w;
        int r;
        logic [7:0] letter;
        para_q.delete();
        tokens = $urandom_range(5, 1);
        for (t = 0; t < tokens; t++) begin
            for (w = 0; w < $urandom_range(4, 1); w++) begin
                if (w == 0 && $urandom_range(9) < 4)
                    letter = CH_UPPER_A + 8'($urandom_range(25));
                else
                    letter = CH_LOWER_A + 8'($urandom_range(25));
                para_q.push_back(letter);
            end
            r = $urandom_range(9);
            case (r)
                0, 1, 2: put_str(" ");
                3:       put_str(". ");
                4:       put_str(($urandom_range(1) == 0) ? "! " : "? ");
                5:       put_str(($urandom_range(1) == 0) ? ".) " : ")");
                6:       put_str(" (");
                7:       put_str(".. ");
                8:       put_str(" . ");
                default: para_q.push_back(8'($urandom_range(255)));
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : driver
        text_item_t item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            ch <= 8'h00;
            para_end <= 1'b0;
            empty_para <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                predict_split(ch, para_end, empty_para);
                sent_count <= sent_count + 1;
            end
            if (!in_valid || in_ready) begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                    item = pending_q.pop_front();
                    ch <= item.ch;
                    para_end <= item.para_end;
                    empty_para <= item.empty_para;
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : monitor
        out_byte_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected output transfer: out_char %h last_of_run %b",
                                 out_char, last_of_run);
                    error_count++;
                end
                else begin
                    want = expected_q.pop_front();
                    if (out_char !== want.out_char || last_of_run !== want.last_flag) begin
                        if (error_count < MAX_REPORTS)
                            $display("mismatch at output %0d: out_char exp %h got %h, last_of_run exp %b got %b",
                                     recv_count, want.out_char, out_char,
                                     want.last_flag, last_of_run);
                        error_count++;
                    end
                end
                recv_count <= recv_count + 1;
                // A long stall here lets the input side fill the block up.
                if (recv_count == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_cycles++;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin : timeout
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : main_seq
        logic [7:0] b;
        int         i;
        clear_para();

        // Directed paragraphs: each mark, a spaced mark before Z, brackets, ellipsis.
        add_text("x? A . Z", 1'b1);
        add_text("(a.)", 1'b1);
        // A mark at paragraph start, then a paragraph closed by an empty line.
        add_text("!)..", 1'b0);
        add_item(8'h00, 1'b1, 1'b1);
        add_text("a.. B", 1'b1);
        // Zero byte and the extremes of the byte range.
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'h01, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1);
        para_count = 6;

        while (pending_q.size() < ITEM_TARGET) begin
            if ($urandom_range(11) == 0) begin
                add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
            else begin
                build_paragraph();
                for (i = 0; i < para_q.size(); i++) begin
                    b = para_q[i];
                    if ($urandom_range(19) == 0)
                        b = 8'($urandom_range(255));
                    add_item(b, 1'b0, 1'b0);
                end
                if ($urandom_range(6) == 0)
                    add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                else
                    add_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end
            para_count++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_q.size() != 0) begin
            $display("%0d predicted output bytes never arrived", expected_q.size());
            error_count++;
        end
        $display("Run covered %0d paragraphs in %0d input transfers and %0d output transfers,",
                 para_count, sent_count, recv_count);
        $display("with %0d cycles of forced output stall and %0d errors.",
                 stall_cycles, error_count);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_front.sv
hw/rtl/sbs_fifo.sv
hw/rtl/sbs_back.sv
hw/rtl/sentence_boundary_splitter.sv
hw/rtl/sbs_checker.sv
test/testbench.sv
